>>> src/awbi_pkg.sv
// ----------------------------------------------------------------------------
// awbi_pkg: shared types and constants of the AND / bitmask immediate unit
// Field widths, stream packing offsets and the decode record passed from the
// decode stage to the element generator.
// ----------------------------------------------------------------------------
package awbi_pkg;

    localparam int unsigned ELEM_LOG_MAX = 6;
    localparam int unsigned DATA_W       = 64;
    localparam int unsigned DEST_W       = 5;
    localparam int unsigned IMM_W        = 6;
    localparam int unsigned LEN_W        = 3;

    // slave tdata: dest_index, first_value, second_value, n_bit, imm_s, imm_r
    localparam int unsigned S_DEST_LSB   = 0;
    localparam int unsigned S_FIRST_LSB  = S_DEST_LSB + DEST_W;
    localparam int unsigned S_SECOND_LSB = S_FIRST_LSB + DATA_W;
    localparam int unsigned S_NBIT_LSB   = S_SECOND_LSB + DATA_W;
    localparam int unsigned S_IMMS_LSB   = S_NBIT_LSB + 1;
    localparam int unsigned S_IMMR_LSB   = S_IMMS_LSB + IMM_W;
    localparam int unsigned S_USED_W     = S_IMMR_LSB + IMM_W;
    localparam int unsigned S_TDATA_W    = ((S_USED_W + 7) / 8) * 8;

    // master tdata: dest_out, result
    localparam int unsigned M_DEST_LSB   = 0;
    localparam int unsigned M_RES_LSB    = M_DEST_LSB + DEST_W;
    localparam int unsigned M_USED_W     = M_RES_LSB + DATA_W;
    localparam int unsigned M_TDATA_W    = ((M_USED_W + 7) / 8) * 8;

    // slave tuser bits
    localparam int unsigned U_MODE       = 0;
    localparam int unsigned U_WIDE       = 1;

    // operand select
    localparam logic MODE_IMM = 1'b0;
    localparam logic MODE_REG = 1'b1;

    // decoded immediate, handed from the decode stage to the element generator
    typedef struct packed {
        logic [LEN_W-1:0] len;   // log2 of element size
        logic [IMM_W-1:0] s;     // ones count minus one, masked to the element
        logic [IMM_W-1:0] r;     // rotation, masked to the element
        logic             inv;   // reserved encoding
    } t_dec;

endpackage

>>> src/awbi_elem_gen.sv
// ----------------------------------------------------------------------------
// awbi_elem_gen: bitmask element builder
// Forms S+1 low ones and replicates the element across 64 bits. Rotation is
// applied afterwards on the replicated word, which equals rotating each element.
// ----------------------------------------------------------------------------
module awbi_elem_gen (
    input  awbi_pkg::t_dec                    i_dec,
    output logic [awbi_pkg::DATA_W-1:0]       o_rep
);

    logic [awbi_pkg::DATA_W-1:0] ones;
    logic [awbi_pkg::DATA_W-1:0] rep;
    logic [awbi_pkg::IMM_W:0]    cnt;

    always_comb begin
        cnt  = {1'b0, i_dec.s} + 7'd1;
        ones = ~({awbi_pkg::DATA_W{1'b1}} << cnt);
        rep  = ones;
        // double the pattern from the element size up to the full word
        for (int i = 0; i < awbi_pkg::ELEM_LOG_MAX; i++) begin
            if (32'(i_dec.len) <= i) begin
                rep = rep | (rep << (2 ** i));
            end
        end
        o_rep = rep;
    end

endmodule

>>> src/and_with_bitmask_immediate_unit.sv
// ----------------------------------------------------------------------------
// and_with_bitmask_immediate_unit: 64/32-bit AND with register or bitmask
// immediate operand
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one instruction item: tuser selects register or immediate
//   operand and the width, tdata carries destination, both sources and the
//   n_bit/imm_s/imm_r immediate fields. m_axis returns one item per input
//   with the destination, the AND result (upper half zero in 32-bit mode) and
//   an invalid flag in tuser for reserved immediate encodings (result zero).
//   Stage 1 decodes the element length and masks S and R, stage 2 builds
//   and replicates the element, stage 3 rotates the pattern, applies the AND
//   and holds the result in the output register. Throughput is one item per
//   cycle while m_axis_tready is high; valid bits travel with each stage.
//   When m_axis_tready is low the output register holds and each stage fills
//   its free slot before s_axis_tready drops, so nothing is lost or repeated.
//   A synchronous active-low reset empties all stages and holds s_axis_tready
//   low while it is asserted.
// ----------------------------------------------------------------------------
module and_with_bitmask_immediate_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [4:0] dest_index, [68:5] first_value, [132:69] second_value,
    // [133] n_bit, [139:134] imm_s, [145:140] imm_r, [151:146] zero
    input  logic [awbi_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [0] mode, [1] wide
    input  logic [1:0]                         s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [4:0] dest_out, [68:5] result, [71:69] zero
    output logic [awbi_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [0] invalid
    output logic                               m_axis_tuser
);

    localparam int unsigned DW = awbi_pkg::DATA_W;

    // stage enables
    logic en1, en2, en3;

    // stage 1
    logic                          r_v1;
    logic                          r_mode1, r_wide1;
    logic [awbi_pkg::DEST_W-1:0]   r_dest1;
    logic [DW-1:0]                 r_a1, r_b1;
    awbi_pkg::t_dec                r_dec1, n_dec1;

    // stage 2
    logic                          r_v2;
    logic                          r_mode2, r_wide2, r_inv2;
    logic [awbi_pkg::DEST_W-1:0]   r_dest2;
    logic [DW-1:0]                 r_a2, r_b2;
    logic [awbi_pkg::IMM_W-1:0]    r_r2;
    logic [DW-1:0]                 r_rep2, n_rep2;

    // stage 3
    logic                          r_v3;
    logic [awbi_pkg::DEST_W-1:0]   r_dest3;
    logic [DW-1:0]                 r_res3, n_res3;
    logic                          r_inv3, n_inv3;

    // decode temporaries
    logic [awbi_pkg::ELEM_LOG_MAX:0] key;
    logic [awbi_pkg::IMM_W-1:0]      levels;
    logic [awbi_pkg::IMM_W-1:0]      in_s, in_r;
    logic                            in_nbit, in_wide;
    logic [DW-1:0]                   rot;

    assign en3           = !r_v3 || m_axis_tready;
    assign en2           = !r_v2 || en3;
    assign en1           = !r_v1 || en2;
    assign s_axis_tready = en1 && i_rst_n;

    assign in_nbit = s_axis_tdata[awbi_pkg::S_NBIT_LSB];
    assign in_s    = s_axis_tdata[awbi_pkg::S_IMMS_LSB +: awbi_pkg::IMM_W];
    assign in_r    = s_axis_tdata[awbi_pkg::S_IMMR_LSB +: awbi_pkg::IMM_W];
    assign in_wide = s_axis_tuser[awbi_pkg::U_WIDE];

    // stage 1 decode: element length from the highest set bit of n_bit:~imm_s
    always_comb begin
        key        = {in_nbit, ~in_s};
        n_dec1.len = '0;
        for (int i = 0; i <= awbi_pkg::ELEM_LOG_MAX; i++) begin
            if (key[i]) begin
                n_dec1.len = awbi_pkg::LEN_W'(i);
            end
        end
        levels   = awbi_pkg::IMM_W'((7'd1 << n_dec1.len) - 7'd1);
        n_dec1.s = in_s & levels;
        n_dec1.r = in_r & levels;
        n_dec1.inv = (key[awbi_pkg::ELEM_LOG_MAX:1] == '0)
                  || (!in_wide && n_dec1.len == awbi_pkg::LEN_W'(awbi_pkg::ELEM_LOG_MAX))
                  || (n_dec1.s == levels);
    end

    awbi_elem_gen u_elem (
        .i_dec (r_dec1),
        .o_rep (n_rep2)
    );

    // stage 3: rotate the replicated pattern, AND, clamp width
    always_comb begin
        rot = (r_rep2 >> r_r2) | (r_rep2 << (7'd64 - {1'b0, r_r2}));
        if (r_mode2 == awbi_pkg::MODE_REG) begin
            n_res3 = r_a2 & r_b2;
            n_inv3 = 1'b0;
        end else if (r_inv2) begin
            n_res3 = '0;
            n_inv3 = 1'b1;
        end else begin
            n_res3 = r_a2 & rot;
            n_inv3 = 1'b0;
        end
        if (!r_wide2) begin
            n_res3[DW-1:DW/2] = '0;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= s_axis_tvalid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_mode1 <= s_axis_tuser[awbi_pkg::U_MODE];
            r_wide1 <= in_wide;
            r_dest1 <= s_axis_tdata[awbi_pkg::S_DEST_LSB +: awbi_pkg::DEST_W];
            r_a1    <= s_axis_tdata[awbi_pkg::S_FIRST_LSB +: DW];
            r_b1    <= s_axis_tdata[awbi_pkg::S_SECOND_LSB +: DW];
            r_dec1  <= n_dec1;
        end
        if (en2) begin
            r_mode2 <= r_mode1;
            r_wide2 <= r_wide1;
            r_inv2  <= r_dec1.inv;
            r_dest2 <= r_dest1;
            r_a2    <= r_a1;
            r_b2    <= r_b1;
            r_r2    <= r_dec1.r;
            r_rep2  <= n_rep2;
        end
        if (en3) begin
            r_dest3 <= r_dest2;
            r_res3  <= n_res3;
            r_inv3  <= n_inv3;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {(awbi_pkg::M_TDATA_W - awbi_pkg::M_USED_W)'(0), r_res3, r_dest3};
    assign m_axis_tuser  = r_inv3;

endmodule

>>> src/awbi_checker.sv
// ----------------------------------------------------------------------------
// awbi_checker: port-level assertions for the AND / bitmask immediate unit
// Output stall behavior, invalid-result form and pipeline latency.
// ----------------------------------------------------------------------------
module awbi_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tready,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [awbi_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    input  logic                               m_axis_tuser
);

    // hold a stalled output item
    a_out_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output item dropped while stalled");

    a_out_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    // a reserved encoding always gives a zero result
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[awbi_pkg::M_RES_LSB +: awbi_pkg::DATA_W] == '0)
        else $error("invalid item with nonzero result");

    // an accepted item reaches the output while the sink keeps m_axis_tready high
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
            |=> m_axis_tvalid)
        else $error("item not delivered within pipeline latency");

endmodule

bind and_with_bitmask_immediate_unit awbi_checker u_awbi_checker (.*);

>>> tb/and_with_bitmask_immediate_unit_test.sv
// ----------------------------------------------------------------------------
// and_with_bitmask_immediate_unit_test: stream testbench of the AND unit
// Drives register and bitmask-immediate AND items, predicts each result with
// an independent decode of the logical immediate, and checks every output item
// in order under random idling on both sides and long back-pressure.
// ----------------------------------------------------------------------------
module and_with_bitmask_immediate_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import awbi_pkg::*;

    typedef struct {
        logic              mode;
        logic              wide;
        logic [DEST_W-1:0] dest;
        logic [DATA_W-1:0] first;
        logic [DATA_W-1:0] second;
        logic              n_bit;
        logic [IMM_W-1:0]  imm_s;
        logic [IMM_W-1:0]  imm_r;
    } and_insn_t;

    typedef struct {
        logic              [DEST_W-1:0] dest;
        logic              [DATA_W-1:0] value;
        logic              invalid;
    } and_result_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // [4:0] dest_index, [68:5] first_value, [132:69] second_value,
    // [133] n_bit, [139:134] imm_s, [145:140] imm_r, [151:146] zero
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    // [0] mode, [1] wide
    logic [1:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [4:0] dest_out, [68:5] result, [71:69] zero
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    // [0] invalid
    logic                  m_axis_tuser;

    and_result_t           pending_results[$];
    int                    mismatch_count = 0;
    bit                    src_idle_en = 1'b0;
    bit                    sink_idle_en = 1'b0;
    int                    sink_hold_cycles = 0;

    and_with_bitmask_immediate_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------------
    function automatic and_result_t predict_and(and_insn_t op);
        and_result_t       res;
        logic [6:0]        key;
        int                len;
        int                esize;
        int                levels;
        int                i;
        logic [IMM_W-1:0]  ones_m1;
        logic [IMM_W-1:0]  rot;
        logic [DATA_W-1:0] emask;
        logic [DATA_W-1:0] elem;
        res.dest    = op.dest;
        res.value   = '0;
        res.invalid = 1'b0;
        if (op.mode == MODE_REG) begin
            res.value = op.first & op.second;
        end else begin
            // element length: highest set bit of N:NOT(imms)
            key = {op.n_bit, ~op.imm_s};
            len = -1;
            for (i = ELEM_LOG_MAX; i >= 0; i--) begin
                if (key[i] && len < 0)
                    len = i;
            end
            if (len < 1 || (!op.wide && len == ELEM_LOG_MAX)) begin
                res.invalid = 1'b1;
            end else begin
                esize   = 1 << len;
                levels  = esize - 1;
                ones_m1 = op.imm_s & levels[IMM_W-1:0];
                rot     = op.imm_r & levels[IMM_W-1:0];
                if (ones_m1 == levels) begin
                    res.invalid = 1'b1;
                end else begin
                    emask = (esize == 64) ? '1 : ((64'd1 << esize) - 64'd1);
                    elem  = (64'd1 << (ones_m1 + 1)) - 64'd1;
                    if (rot != 0)
                        elem = ((elem >> rot) | (elem << (esize - rot))) & emask;
                    for (i = esize; i < 64; i = i * 2)
                        elem = elem | (elem << i);
                    res.value = op.first & elem;
                end
            end
        end
        if (!op.wide)
            res.value[63:32] = '0;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic and_insn_t make_insn(logic mode, logic wide, logic [DEST_W-1:0] dest,
                                            logic [DATA_W-1:0] first,
                                            logic [DATA_W-1:0] second, logic n_bit,
                                            logic [IMM_W-1:0] imm_s,
                                            logic [IMM_W-1:0] imm_r);
        and_insn_t op;
        op.mode   = mode;
        op.wide   = wide;
        op.dest   = dest;
        op.first  = first;
        op.second = second;
        op.n_bit  = n_bit;
        op.imm_s  = imm_s;
        op.imm_r  = imm_r;
        return op;
    endfunction

    // imms for a legal element of 2^len bits holding ones_m1+1 ones
    function automatic logic [IMM_W-1:0] encode_imm_s(int len, int ones_m1);
        logic [IMM_W-1:0] v;
        v = 6'h3F << (len + 1);
        v = v | ones_m1[IMM_W-1:0];
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 16)
            return $urandom_range(1, 3);
        else if (r < 19)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic and_insn_t random_insn();
        and_insn_t op;
        int        kind;
        int        len;
        op.wide   = 1'($urandom_range(0, 1));
        op.dest   = DEST_W'($urandom);
        op.first  = ($urandom_range(0, 9) == 0) ? '1 : {$urandom, $urandom};
        op.second = ($urandom_range(0, 9) == 0) ? '1 : {$urandom, $urandom};
        op.n_bit  = 1'($urandom_range(0, 1));
        op.imm_s  = IMM_W'($urandom);
        op.imm_r  = IMM_W'($urandom);
        kind = $urandom_range(0, 19);
        if (kind < 12) begin
            // well-formed immediate with random element, ones and rotation
            op.mode  = MODE_IMM;
            len      = $urandom_range(1, op.wide ? 6 : 5);
            op.n_bit = (len == 6);
            op.imm_s = encode_imm_s(len, $urandom_range(0, (1 << len) - 2));
        end else if (kind < 17) begin
            op.mode = MODE_REG;
        end else begin
            op.mode = MODE_IMM;
        end
        return op;
    endfunction

    // ------------------------------------------------------------------------
    // source side
    // ------------------------------------------------------------------------
    task automatic send_insn(input and_insn_t op);
        logic [S_TDATA_W-1:0] word;
        int                   gap;
        word = '0;
        word[S_DEST_LSB +: DEST_W]   = op.dest;
        word[S_FIRST_LSB +: DATA_W]  = op.first;
        word[S_SECOND_LSB +: DATA_W] = op.second;
        word[S_NBIT_LSB]             = op.n_bit;
        word[S_IMMS_LSB +: IMM_W]    = op.imm_s;
        word[S_IMMR_LSB +: IMM_W]    = op.imm_r;
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            gap = pick_gap();
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= {op.wide, op.mode};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_results.push_back(predict_and(op));
    endtask

    // drop valid and hold until every predicted item has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // sink side
    // ------------------------------------------------------------------------
    initial begin : sink_ready_driver
        int stall_len;
        forever begin
            @(posedge i_clk);
            if (sink_hold_cycles != 0) begin
                stall_len = sink_hold_cycles;
                sink_hold_cycles = 0;
                m_axis_tready <= 1'b0;
                repeat (stall_len - 1) @(posedge i_clk);
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                stall_len = pick_gap();
                m_axis_tready <= 1'b0;
                repeat (stall_len - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic flag_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        and_result_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                flag_mismatch("unexpected item", m_axis_tdata[M_RES_LSB +: DATA_W], '0);
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tdata[M_DEST_LSB +: DEST_W] !== want.dest)
                    flag_mismatch("dest_out", DATA_W'(m_axis_tdata[M_DEST_LSB +: DEST_W]),
                                  DATA_W'(want.dest));
                if (m_axis_tdata[M_RES_LSB +: DATA_W] !== want.value)
                    flag_mismatch("result", m_axis_tdata[M_RES_LSB +: DATA_W], want.value);
                if (m_axis_tuser !== want.invalid)
                    flag_mismatch("invalid", DATA_W'(m_axis_tuser), DATA_W'(want.invalid));
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_register_mode();
        send_insn(make_insn(MODE_REG, 1'b1, 5'd0, '1, '1, 1'b0, 6'd0, 6'd0));
        send_insn(make_insn(MODE_REG, 1'b1, 5'd31, {16{4'hA}}, '1, 1'b0, 6'd0, 6'd0));
        // reserved immediate fields have no effect in register mode
        send_insn(make_insn(MODE_REG, 1'b0, 5'd17, '1, {16{4'h5}}, 1'b1, 6'h3F, 6'h3F));
        send_insn(make_insn(MODE_REG, 1'b1, 5'd9, '0, '1, 1'b0, 6'h3E, 6'h2A));
    endtask

    task automatic test_immediate_directed();
        int len;
        int levels;
        for (len = 1; len <= 6; len++) begin
            levels = (1 << len) - 1;
            send_insn(make_insn(MODE_IMM, 1'b1, len[4:0], '1, '0, len == 6,
                                encode_imm_s(len, 0), 6'd0));
            send_insn(make_insn(MODE_IMM, 1'b1, 5'd31 - len[4:0], '1, '1, len == 6,
                                encode_imm_s(len, levels - 1), levels[5:0]));
        end
        // undefined element length
        send_insn(make_insn(MODE_IMM, 1'b1, 5'd3, '1, '0, 1'b0, 6'b111110, 6'd0));
        send_insn(make_insn(MODE_IMM, 1'b0, 5'd4, '1, '0, 1'b0, 6'b111111, 6'h3F));
        // all-ones S for a 32-bit element
        send_insn(make_insn(MODE_IMM, 1'b1, 5'd5, '1, '0, 1'b0, 6'b011111, 6'd1));
        // 64-bit element asked for in 32-bit mode
        send_insn(make_insn(MODE_IMM, 1'b0, 5'd6, '1, '0, 1'b1, 6'd10, 6'd3));
        // legal 32-bit element, result zero-extended
        send_insn(make_insn(MODE_IMM, 1'b0, 5'd7, '1, '1, 1'b0, 6'd30, 6'd31));
    endtask

    task automatic test_random_mix(int count);
        int k;
        for (k = 0; k < count; k++) begin
            // every hundred items, pick anew whether each side idles or runs back to back
            if (k % 100 == 0) begin
                src_idle_en  = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
            end
            send_insn(random_insn());
        end
    endtask

    task automatic test_back_pressure();
        int k;
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        sink_hold_cycles = 250;
        for (k = 0; k < 60; k++)
            send_insn(random_insn());
    endtask

    task automatic test_drain_pause();
        int k;
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        for (k = 0; k < 20; k++)
            send_insn(random_insn());
        wait_drained();
        for (k = 0; k < 20; k++)
            send_insn(random_insn());
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_register_mode();
        test_immediate_directed();
        test_drain_pause();
        test_back_pressure();
        test_random_mix(730);
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
